/* src/itrd_pkg.sv */
package itrd_pkg;

   localparam int VALUE_BITS_DEFAULT = 31;

   localparam int RADIX_BITS = 6;
   localparam int CHAR_BITS  = 7;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
   localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

   localparam logic [RADIX_BITS-1:0] DECIMAL_DIGITS = 6'd10;
   localparam logic [CHAR_BITS-1:0]  ASCII_ZERO     = 7'd48;
   localparam logic [CHAR_BITS-1:0]  ASCII_UPPER_A  = 7'd65;
   localparam logic [CHAR_BITS-1:0]  ASCII_NINE     = 7'd57;
   localparam logic [CHAR_BITS-1:0]  ASCII_UPPER_Z  = 7'd90;

   // register file: one register, index taken from paddr[2]
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic REG_RADIX = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_READ,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;    // capture value and radix, clear digit count
      logic divide;  // one restoring division step
      logic push;    // store remainder, start next digit
      logic emit;    // move popped digit to output register
   } dp_cmd_type;

   typedef struct packed {
      logic step_done;   // current step is the last of this digit
      logic quot_zero;   // quotient after this step is zero
      logic count_full;  // stack holds all but one entry
      logic ptr_zero;    // popping the bottom entry
      logic out_free;    // output register can take a digit
   } dp_status_type;

endpackage

/* src/itrd_ctrl.sv */
module itrd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  itrd_pkg::dp_status_type status,
   output itrd_pkg::dp_cmd_type    cmd
);

   itrd_pkg::state_type state_ff;
   itrd_pkg::state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = itrd_pkg::ST_DIVIDE;
         end
         itrd_pkg::ST_DIVIDE: begin
            if (status.step_done && (status.quot_zero || status.count_full)) begin
               state_in = itrd_pkg::ST_READ;
            end
         end
         itrd_pkg::ST_READ: begin
            state_in = itrd_pkg::ST_EMIT;
         end
         itrd_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = status.ptr_zero ? itrd_pkg::ST_IDLE : itrd_pkg::ST_READ;
            end
         end
         default: state_in = itrd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         itrd_pkg::ST_DIVIDE: begin
            cmd.divide = 1'b1;
            cmd.push   = status.step_done;
         end
         itrd_pkg::ST_READ: begin
            cmd = '0;
         end
         itrd_pkg::ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itrd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/itrd_dp.sv */
module itrd_dp #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [VALUE_BITS-1:0]           value,
   input  logic [itrd_pkg::RADIX_BITS-1:0] radix,
   input  itrd_pkg::dp_cmd_type            cmd,
   output itrd_pkg::dp_status_type         status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itrd_pkg::CHAR_BITS-1:0]  rsp_char,
   output logic                            rsp_tlast
);

   localparam int IDX_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int RB       = itrd_pkg::RADIX_BITS;

   logic [VALUE_BITS-1:0] dividend_ff, dividend_in;
   logic [RB-1:0]         rem_ff, rem_in;
   logic [RB-1:0]         radix_ff;
   logic [IDX_BITS-1:0]   step_ff, step_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [IDX_BITS-1:0]   ptr_ff, ptr_in;
   logic [RB-1:0]         rd_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [itrd_pkg::CHAR_BITS-1:0] rsp_char_ff;
   logic                  rsp_last_ff;

   logic [RB-1:0] stack_mem [VALUE_BITS];

   logic [RB:0]           shifted;
   logic                  quot_bit;
   logic [RB-1:0]         rem_next;
   logic [VALUE_BITS-1:0] quot_next;
   logic [itrd_pkg::CHAR_BITS-1:0] char_next;

   // restoring division, one quotient bit per cycle; quotient shifts into the dividend
   always_comb begin
      shifted   = {rem_ff, dividend_ff[VALUE_BITS-1]};
      quot_bit  = (shifted >= {1'b0, radix_ff});
      rem_next  = quot_bit ? RB'(shifted - {1'b0, radix_ff}) : shifted[RB-1:0];
      quot_next = {dividend_ff[VALUE_BITS-2:0], quot_bit};
   end

   always_comb begin
      if (rd_data_ff < itrd_pkg::DECIMAL_DIGITS) begin
         char_next = itrd_pkg::ASCII_ZERO + {1'b0, rd_data_ff};
      end else begin
         char_next = itrd_pkg::ASCII_UPPER_A
                   + {1'b0, RB'(rd_data_ff - itrd_pkg::DECIMAL_DIGITS)};
      end
   end

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      step_in     = step_ff;
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      priority if (cmd.load) begin
         dividend_in = value;
         rem_in      = '0;
         step_in     = IDX_BITS'(VALUE_BITS - 1);
         count_in    = '0;
      end else if (cmd.push) begin
         dividend_in = quot_next;
         rem_in      = '0;
         step_in     = IDX_BITS'(VALUE_BITS - 1);
         count_in    = count_ff + CNT_BITS'(1);
         ptr_in      = count_ff[IDX_BITS-1:0];
      end else if (cmd.divide) begin
         dividend_in = quot_next;
         rem_in      = rem_next;
         step_in     = step_ff - IDX_BITS'(1);
      end else if (cmd.emit) begin
         ptr_in      = ptr_ff - IDX_BITS'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      step_ff     <= step_in;
      ptr_ff      <= ptr_in;
      if (cmd.load) radix_ff <= radix;
      if (cmd.emit) begin
         rsp_char_ff <= char_next;
         rsp_last_ff <= (ptr_ff == '0);
      end
   end

   // remainder stack
   always_ff @(posedge clock) begin
      if (cmd.push) stack_mem[count_ff[IDX_BITS-1:0]] <= rem_next;
      rd_data_ff <= stack_mem[ptr_ff];
   end

   always_comb begin
      status.step_done  = (step_ff == '0);
      status.quot_zero  = (quot_next == '0);
      status.count_full = (count_ff == CNT_BITS'(VALUE_BITS - 1));
      status.ptr_zero   = (ptr_ff == '0);
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_char   = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_push_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> (count_ff < CNT_BITS'(VALUE_BITS)))
      else $error("remainder pushed past stack depth");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("digit emitted over a pending transfer");

   a_last_on_bottom: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && status.ptr_zero) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("bottom of stack not flagged last");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_char_ff >= itrd_pkg::ASCII_ZERO
                         && rsp_char_ff <= itrd_pkg::ASCII_NINE)
                        || (rsp_char_ff >= itrd_pkg::ASCII_UPPER_A
                            && rsp_char_ff <= itrd_pkg::ASCII_UPPER_Z)))
      else $error("digit character out of range");

endmodule

/* src/integer_to_radix_digits.sv */
// Channel  Direction  Handshake            Payload
// req      in         req_tvalid/tready    tdata: value
// rsp      out        rsp_tvalid/tready    tdata: digit_char, tlast: last_digit
// csr      in         APB write, no wait   register 0: radix (saturated 2..36)
//
// Each digit is found by the bit-serial restoring divider, then popped from the
// remainder stack through a registered memory read (states READ, then EMIT).
// Reset (synchronous) sets radix to 10 and empties the output register.
// A stalled rsp holds the pop; the next item is taken once the last digit
// sits in the output register.
module integer_to_radix_digits #(
   parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [VALUE_BITS-1:0] value, zero fill above
   input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [6:0] digit_char, [7] zero
   output logic [7:0]                           rsp_tdata,
   output logic                                 rsp_tlast,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [itrd_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [itrd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [itrd_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam int RB = itrd_pkg::RADIX_BITS;

   logic [RB-1:0] radix_ff, radix_in;
   logic          csr_hit;
   logic          csr_wr;
   logic [RB-1:0] wr_radix;
   logic [itrd_pkg::CHAR_BITS-1:0] rsp_char;

   itrd_pkg::dp_cmd_type    cmd;
   itrd_pkg::dp_status_type status;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == itrd_pkg::REG_RADIX);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign wr_radix   = csr_pwdata[RB-1:0];

   always_comb begin
      radix_in = radix_ff;
      if (csr_wr) begin
         priority if (wr_radix < itrd_pkg::RADIX_MIN) begin
            radix_in = itrd_pkg::RADIX_MIN;
         end else if (wr_radix > itrd_pkg::RADIX_MAX) begin
            radix_in = itrd_pkg::RADIX_MAX;
         end else begin
            radix_in = wr_radix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= itrd_pkg::RADIX_RESET;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign csr_prdata = csr_hit ? {{(itrd_pkg::CSR_DATA_BITS - RB){1'b0}}, radix_ff} : '0;

   itrd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   itrd_dp #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .value      (req_tdata[VALUE_BITS-1:0]),
      .radix      (radix_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_char   (rsp_char),
      .rsp_tlast  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

/* verif/tb_integer_to_radix_digits.sv */
module tb_integer_to_radix_digits;

   localparam int VB         = itrd_pkg::VALUE_BITS_DEFAULT;
   localparam int DATA_W     = ((VB + 7) / 8) * 8;
   localparam int RB         = itrd_pkg::RADIX_BITS;
   localparam int CB         = itrd_pkg::CHAR_BITS;
   localparam int AB         = itrd_pkg::CSR_ADDR_BITS;
   localparam int CYCLE_CAP  = 3_000_000;
   localparam int PHASES     = 8;
   localparam int PHASE_ITEMS = 39;

   // byte addresses on the csr port: radix at index 0, index 1 is unmapped
   localparam logic [AB-1:0] ADDR_RADIX = 3'd0;
   localparam logic [AB-1:0] ADDR_SPARE = 3'd4;

   typedef enum bit {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic [AB-1:0] addr;
      logic [31:0]  data;
      string        spelled;   // empty: expected digits come from the predictor
   } plan_row_type;

   typedef struct {
      logic [CB-1:0] ch;
      logic          last;
   } due_digit_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [DATA_W-1:0]                    req_tdata = '0;   // [30:0] value, [31] fill, ignored by the design
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b1;
   logic [7:0]                           rsp_tdata;        // [6:0] digit_char, [7] zero
   logic                                 rsp_tlast;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [AB-1:0]                        csr_paddr = '0;
   logic [itrd_pkg::CSR_DATA_BITS-1:0]   csr_pwdata = '0;
   logic [itrd_pkg::CSR_DATA_BITS-1:0]   csr_prdata;
   logic                                 csr_pready;

   integer_to_radix_digits uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   due_digit_type         digits_due[$];
   due_digit_type         head;
   logic [RB-1:0]         radix_now = itrd_pkg::RADIX_RESET;
   bit                    calm = 1'b0;
   int                    errors = 0;
   int                    values_sent = 0;
   int                    digits_seen = 0;
   int                    radix_writes = 0;
   int                    cycles = 0;
   int                    stall_left = 0;

   plan_row_type plan [0:27] = '{
      '{ROW_ITEM, 3'd0, 32'd0,          "0"},
      '{ROW_ITEM, 3'd0, 32'd2147483647, "2147483647"},
      '{ROW_ITEM, 3'd0, 32'd9,          "9"},
      '{ROW_ITEM, 3'd0, 32'd10,         "10"},
      '{ROW_ITEM, 3'd0, 32'h8000_0000,  "0"},
      '{ROW_ITEM, 3'd0, 32'hFFFF_FFFF,  "2147483647"},
      '{ROW_CSR,  ADDR_SPARE, 32'd3,    ""},
      '{ROW_ITEM, 3'd0, 32'd1234,       "1234"},
      '{ROW_CSR,  ADDR_RADIX, 32'd0,    ""},
      '{ROW_ITEM, 3'd0, 32'd2147483647, "1111111111111111111111111111111"},
      '{ROW_ITEM, 3'd0, 32'd1,          "1"},
      '{ROW_ITEM, 3'd0, 32'd0,          "0"},
      '{ROW_CSR,  ADDR_RADIX, 32'd1,    ""},
      '{ROW_ITEM, 3'd0, 32'd6,          "110"},
      '{ROW_CSR,  ADDR_RADIX, 32'd63,   ""},
      '{ROW_ITEM, 3'd0, 32'd2147483647, "ZIK0ZJ"},
      '{ROW_ITEM, 3'd0, 32'd35,         "Z"},
      '{ROW_ITEM, 3'd0, 32'd36,         "10"},
      '{ROW_CSR,  ADDR_RADIX, 32'd37,   ""},
      '{ROW_ITEM, 3'd0, 32'd10,         "A"},
      '{ROW_CSR,  ADDR_RADIX, 32'hFFFF_FF50, ""},
      '{ROW_ITEM, 3'd0, 32'h7FFF_FFFF,  "7FFFFFFF"},
      '{ROW_ITEM, 3'd0, 32'd255,        "FF"},
      '{ROW_CSR,  ADDR_RADIX, 32'd7,    ""},
      '{ROW_ITEM, 3'd0, 32'd123456789,  ""},
      '{ROW_ITEM, 3'd0, 32'd2147483647, ""},
      '{ROW_CSR,  ADDR_RADIX, 32'd35,   ""},
      '{ROW_ITEM, 3'd0, 32'd1295,       ""}
   };

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [RB-1:0] clamp_radix(input logic [31:0] wdata);
      logic [RB-1:0] v;
      v = wdata[RB-1:0];
      if (v < itrd_pkg::RADIX_MIN) v = itrd_pkg::RADIX_MIN;
      if (v > itrd_pkg::RADIX_MAX) v = itrd_pkg::RADIX_MAX;
      return v;
   endfunction

   // divide down by the current radix, then queue the digits top first
   function automatic void spell_value(input logic [VB-1:0] value);
      logic [VB-1:0]         n;
      logic [RB-1:0]         rem [VB];
      logic [RB-1:0]         r;
      int                    cnt;
      due_digit_type         d;
      n = value;
      cnt = 0;
      if (n == 0) begin
         rem[0] = '0;
         cnt = 1;
      end else begin
         while (n != 0 && cnt < VB) begin
            rem[cnt] = RB'(n % radix_now);
            n = n / radix_now;
            cnt++;
         end
      end
      for (int k = 0; k < cnt; k++) begin
         r = rem[cnt - 1 - k];
         if (r < itrd_pkg::DECIMAL_DIGITS)
            d.ch = itrd_pkg::ASCII_ZERO + CB'(r);
         else
            d.ch = itrd_pkg::ASCII_UPPER_A + CB'(r - itrd_pkg::DECIMAL_DIGITS);
         d.last = (k == cnt - 1);
         digits_due.push_back(d);
      end
   endfunction

   function automatic logic [31:0] pick_value();
      longint p;
      int     k;
      unique case ($urandom_range(0, 4))
         0: return {($urandom_range(0, 9) == 0), 31'($urandom)};
         1: return 32'($urandom_range(0, 1000));
         2: return 32'($urandom) >> $urandom_range(1, 31);
         3: begin
            // land just on or below a power of the radix
            p = 1;
            k = $urandom_range(1, VB);
            repeat (k) if (p * radix_now < (64'd1 << VB)) p = p * radix_now;
            return 32'(p - $urandom_range(0, 1));
         end
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'd0;
      endcase
   endfunction

   task automatic send_value(input logic [31:0] word, input string spelled);
      due_digit_type d;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      values_sent++;
      if (spelled.len() == 0) begin
         spell_value(word[VB-1:0]);
      end else begin
         for (int i = 0; i < spelled.len(); i++) begin
            d.ch   = CB'(spelled[i]);
            d.last = (i == spelled.len() - 1);
            digits_due.push_back(d);
         end
      end
   endtask

   // let every digit of the items in flight come out, block is then idle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (digits_due.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_transfer(input logic wr, input logic [AB-1:0] addr,
                               input logic [31:0] wdata, output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_radix_reg(input logic [AB-1:0] addr,
                                  input logic [31:0] wdata);
      logic [31:0] rd;
      csr_transfer(1'b1, addr, wdata, rd);
      if (addr[2] == itrd_pkg::REG_RADIX) begin
         radix_now = clamp_radix(wdata);
         radix_writes++;
      end
      csr_transfer(1'b0, ADDR_RADIX, 32'd0, rd);
      if (rd[RB-1:0] !== radix_now) begin
         errors++;
         $display("%0t: radix readback expected %0d, got %0d", $time, radix_now,
                  rd[RB-1:0]);
      end
   endtask

   // result side: random stall bursts, none once the run goes calm
   always @(posedge clock) begin
      if (reset || calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 9) < 2) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (digits_due.size() == 0) begin
            errors++;
            $display("%0t: digit transfer with nothing expected, got 0x%02h last %0b",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            head = digits_due.pop_front();
            digits_seen++;
            if (rsp_tdata !== {1'b0, head.ch} || rsp_tlast !== head.last) begin
               errors++;
               $display("%0t: expected '%c' last %0b, got 0x%02h last %0b", $time,
                        head.ch, head.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("%0t: timeout, %0d digits still due", $time, digits_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_radix_reg(plan[i].addr, plan[i].data);
         end else begin
            send_value(plan[i].data, plan[i].spelled);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         calm = (ph == PHASES - 1);
         if (ph == 3)
            write_radix_reg(ADDR_SPARE, $urandom);
         unique case (ph)
            0:       write_radix_reg(ADDR_RADIX, 32'd2);
            1:       write_radix_reg(ADDR_RADIX, 32'd36);
            default: write_radix_reg(ADDR_RADIX, $urandom);
         endcase
         repeat (PHASE_ITEMS) send_value(pick_value(), "");
      end

      drain();
      repeat (64) @(posedge clock);
      $display("Converted %0d values into %0d digits over %0d radix settings", values_sent,
               digits_seen, radix_writes);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
